### rtl/bc_pkg.sv
// Shared types and constants for the binomial coefficient unit.
package bc_pkg;

    localparam int FIELD_WIDTH = 64;
    localparam int MUL_DIGIT   = 16;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_ONE   = 2'd1,
        RES_VALUE = 2'd2,
        RES_OVF   = 2'd3
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      setup;
        logic      mul_init;
        logic      mul_step;
        logic      div_step;
        logic      advance;
        logic      out_load;
        res_kind_t out_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic k_gt_n;
        logic trivial;
        logic loop_done;
        logic ovf;
    } dp_stat_t;

endpackage

### rtl/bc_in_if.sv
// Operand channel: n and k with valid/ready handshake.
interface bc_in_if import bc_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] n_total;
    logic [FIELD_WIDTH-1:0] k_chosen;

    modport source (output valid, output n_total, output k_chosen, input ready);
    modport sink   (input valid, input n_total, input k_chosen, output ready);
endinterface

### rtl/bc_out_if.sv
// Result channel: coefficient and overflow flag with valid/ready handshake.
interface bc_out_if import bc_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] coefficient;
    logic                   overflow;

    modport source (output valid, output coefficient, output overflow, input ready);
    modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface

### rtl/bc_datapath.sv
// Datapath: operand registers, digit-serial multiplier, restoring divider, result register.
module bc_datapath import bc_pkg::*; #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   clk,
    input  logic [VALUE_WIDTH-1:0] n_in,
    input  logic [VALUE_WIDTH-1:0] k_in,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    output logic [VALUE_WIDTH-1:0] coefficient,
    output logic                   overflow
);

    localparam int W      = VALUE_WIDTH;
    localparam int DIGITS = (W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int MW     = DIGITS * MUL_DIGIT;
    localparam int PW     = W + MUL_DIGIT;
    localparam int AW     = 2 * W;
    localparam int SW     = AW + MUL_DIGIT;

    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  k_reg, k_next;
    logic [W-1:0]  kmin_reg, kmin_next;
    logic [W-1:0]  mterm_reg, mterm_next;
    logic [W-1:0]  i_reg, i_next;
    logic [W-1:0]  value_reg, value_next;
    logic [MW-1:0] mul_reg, mul_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [W-1:0]  coef_reg, coef_next;
    logic          ovf_reg, ovf_next;

    logic [W-1:0]  n_minus_k;
    logic [PW-1:0] partial;
    logic [SW-1:0] mac_sum;
    logic [W-1:0]  acc_hi;
    logic [W-1:0]  acc_lo;
    logic [W:0]    rem_shift;
    logic [W:0]    rem_diff;
    logic          rem_ge;

    assign n_minus_k = n_reg - k_reg;
    assign acc_hi    = acc_reg[AW-1:W];
    assign acc_lo    = acc_reg[W-1:0];

    // value times the top digit of the multiplier, folded into the shifted accumulator
    assign partial = value_reg * mul_reg[MW-1 -: MUL_DIGIT];
    assign mac_sum = {acc_reg, {MUL_DIGIT{1'b0}}} + {{(SW-PW){1'b0}}, partial};

    // one restoring step; remainder stays below i, so W+1 bits hold the shifted value
    assign rem_shift = {acc_hi, acc_lo[W-1]};
    assign rem_ge    = rem_shift >= {1'b0, i_reg};
    assign rem_diff  = rem_shift - {1'b0, i_reg};

    assign stat.k_gt_n    = k_reg > n_reg;
    assign stat.trivial   = (k_reg == '0) || (k_reg == n_reg);
    assign stat.loop_done = i_reg > kmin_reg;
    // quotient fits in W bits exactly when the product's high half is below i
    assign stat.ovf       = acc_hi >= i_reg;

    always_comb
    begin
        n_next     = n_reg;
        k_next     = k_reg;
        kmin_next  = kmin_reg;
        mterm_next = mterm_reg;
        i_next     = i_reg;
        value_next = value_reg;
        mul_next   = mul_reg;
        acc_next   = acc_reg;
        coef_next  = coef_reg;
        ovf_next   = ovf_reg;

        if (cmd.load)
        begin
            n_next = n_in;
            k_next = k_in;
        end
        if (cmd.setup)
        begin
            kmin_next  = (k_reg > n_minus_k) ? n_minus_k : k_reg;
            value_next = W'(1);
            mterm_next = n_reg;
            i_next     = W'(1);
        end
        if (cmd.mul_init)
        begin
            mul_next = MW'(mterm_reg);
            acc_next = '0;
        end
        if (cmd.mul_step)
        begin
            mul_next = mul_reg << MUL_DIGIT;
            acc_next = mac_sum[AW-1:0];
        end
        if (cmd.div_step)
        begin
            acc_next = {(rem_ge ? rem_diff[W-1:0] : rem_shift[W-1:0]),
                        acc_lo[W-2:0], rem_ge};
        end
        if (cmd.advance)
        begin
            value_next = acc_lo;
            mterm_next = mterm_reg - W'(1);
            i_next     = i_reg + W'(1);
        end
        if (cmd.out_load)
        begin
            unique case (cmd.out_kind)
                RES_ZERO:  coef_next = '0;
                RES_ONE:   coef_next = W'(1);
                RES_VALUE: coef_next = value_reg;
                RES_OVF:   coef_next = '1;
                default:   coef_next = '0;
            endcase
            ovf_next = (cmd.out_kind == RES_OVF);
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        k_reg     <= k_next;
        kmin_reg  <= kmin_next;
        mterm_reg <= mterm_next;
        i_reg     <= i_next;
        value_reg <= value_next;
        mul_reg   <= mul_next;
        acc_reg   <= acc_next;
        coef_reg  <= coef_next;
        ovf_reg   <= ovf_next;
    end

    assign coefficient = coef_reg;
    assign overflow    = ovf_reg;

endmodule

### rtl/bc_control.sv
// Controller: sequences setup, multiply, overflow check, divide and result hand-off.
module bc_control import bc_pkg::*; #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam int W      = VALUE_WIDTH;
    localparam int DIGITS = (W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int CW     = $clog2(W);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SETUP  = 8'b0000_0010,
        ST_LOOP   = 8'b0000_0100,
        ST_MUL    = 8'b0000_1000,
        ST_CHECK  = 8'b0001_0000,
        ST_DIV    = 8'b0010_0000,
        ST_NEXT   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    res_kind_t kind_reg, kind_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.out_kind = kind_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                priority if (stat.k_gt_n)
                begin
                    kind_next  = RES_ZERO;
                    state_next = ST_FINISH;
                end
                else if (stat.trivial)
                begin
                    kind_next  = RES_ONE;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.setup  = 1'b1;
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (stat.loop_done)
                begin
                    kind_next  = RES_VALUE;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.mul_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIGITS - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.ovf)
                begin
                    kind_next  = RES_OVF;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_LOOP;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            kind_reg      <= RES_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/binomial_coefficient.sv
// Top level of the binomial coefficient unit.
//
// Computes C(n,k) for unsigned VALUE_WIDTH-bit n and k (input bits above
// VALUE_WIDTH are ignored) by the multiplicative rule, one item at a time.
// k above n gives 0; k of zero or equal to n gives 1. Otherwise the loop
// runs i = 1..min(k, n-k); each iteration multiplies the running value by
// n-i+1 in a 16-bit-digit serial multiplier, checks that the quotient
// fits, then divides by i with a restoring divider at one quotient bit
// per cycle, and then advances the loop. Iterations stop early on
// overflow, which saturates the coefficient to all ones and sets
// overflow. A new item is accepted once the previous one has been placed
// in the output register, even if that result has not yet been taken.
module binomial_coefficient import bc_pkg::*; #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    bc_in_if.sink    operands,
    bc_out_if.source result
);

    dp_cmd_t                cmd;
    dp_stat_t               stat;
    logic [VALUE_WIDTH-1:0] coef;
    logic                   ovf;

    bc_control #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .n_in        (operands.n_total[VALUE_WIDTH-1:0]),
        .k_in        (operands.k_chosen[VALUE_WIDTH-1:0]),
        .cmd         (cmd),
        .stat        (stat),
        .coefficient (coef),
        .overflow    (ovf)
    );

    assign result.coefficient = FIELD_WIDTH'(coef);
    assign result.overflow    = ovf;

endmodule

### verif/tb_binomial_coefficient.sv
// Self-checking testbench for the binomial coefficient unit.
module tb_binomial_coefficient;
    import bc_pkg::*;

    localparam int VALUE_W = 64;
    localparam logic [FIELD_WIDTH-1:0] VAL_MASK = {FIELD_WIDTH{1'b1}} >> (FIELD_WIDTH - VALUE_W);
    localparam logic [FIELD_WIDTH-1:0] ALL_ONES = {FIELD_WIDTH{1'b1}};

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] coefficient;
        logic                   overflow;
    } coef_result_t;

    logic clk;
    logic rst_n;

    bc_in_if  operands_ch ();
    bc_out_if result_ch ();

    binomial_coefficient #(
        .VALUE_WIDTH(VALUE_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_ch),
        .result   (result_ch)
    );

    coef_result_t pending_results[$];
    int           n_errors      = 0;
    int           items_sent    = 0;
    int           results_taken = 0;
    int           overflows     = 0;
    int           zeros         = 0;
    int           hold_request  = 0;
    bit           no_gaps       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #30000000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("binomial_coefficient: mismatch");
        $finish;
    end

    // Exact C(n,k) at VALUE_W bits, saturating when a partial quotient overflows.
    function automatic coef_result_t predict_coefficient(input logic [FIELD_WIDTH-1:0] n_in,
                                                         input logic [FIELD_WIDTH-1:0] k_in);
        logic [FIELD_WIDTH-1:0] n;
        logic [FIELD_WIDTH-1:0] k;
        logic [FIELD_WIDTH-1:0] value;
        logic [FIELD_WIDTH-1:0] i;
        logic [127:0]           prod;
        logic [127:0]           quot;
        coef_result_t           r;
        n = n_in & VAL_MASK;
        k = k_in & VAL_MASK;
        r.coefficient = '0;
        r.overflow    = 1'b0;
        if (k > n)
            return r;
        if (k == 0 || k == n)
        begin
            r.coefficient = 1;
            return r;
        end
        if (k > n - k)
            k = n - k;
        value = 1;
        for (i = 1; i <= k; i++)
        begin
            prod = 128'(value) * 128'(n - i + 1);
            quot = prod / 128'(i);
            if (quot > 128'(VAL_MASK))
            begin
                r.coefficient = VAL_MASK;
                r.overflow    = 1'b1;
                return r;
            end
            value = quot[FIELD_WIDTH-1:0];
        end
        r.coefficient = value & VAL_MASK;
        return r;
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Leaves valid high on return so a gapless next item keeps it asserted.
    task automatic send_operands(input logic [FIELD_WIDTH-1:0] n,
                                 input logic [FIELD_WIDTH-1:0] k);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            operands_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operands_ch.valid    <= 1'b1;
        operands_ch.n_total  <= n;
        operands_ch.k_chosen <= k;
        do
            @(posedge clk);
        while (!operands_ch.ready);
        pending_results.push_back(predict_coefficient(n, k));
        items_sent++;
    endtask

    task automatic wait_for_results();
        operands_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Result side: draws a stall per item, then takes and checks one item.
    initial
    begin
        int           stall;
        coef_result_t want;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (hold_request != 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            results_taken++;
            if (result_ch.overflow)
                overflows++;
            if (result_ch.coefficient == 0)
                zeros++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result coefficient=%h overflow=%b", $time,
                         result_ch.coefficient, result_ch.overflow);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.coefficient !== want.coefficient)
                begin
                    $display("%0t: coefficient expected %h actual %h", $time,
                             want.coefficient, result_ch.coefficient);
                    n_errors++;
                end
                if (result_ch.overflow !== want.overflow)
                begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             want.overflow, result_ch.overflow);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_edge_operands();
        send_operands(3, 7);                        // k above n
        send_operands(0, 1);
        send_operands(ALL_ONES - 1, ALL_ONES);
        send_operands(0, ALL_ONES);
        send_operands(0, 0);                        // k zero
        send_operands(9, 0);
        send_operands(ALL_ONES, 0);
        send_operands(ALL_ONES, ALL_ONES);          // k equal to n
        send_operands(12, 12);
        send_operands(10, 3);
        send_operands(10, 7);                       // swapped to n-k
        send_operands(2, 1);
        send_operands(ALL_ONES, 1);                 // largest value that fits
        send_operands(ALL_ONES, ALL_ONES - 1);
        send_operands(ALL_ONES, 2);                 // overflow on the second step
        send_operands(ALL_ONES, ALL_ONES - 2);
        send_operands(67, 33);                      // longest loop without overflow
        send_operands(67, 34);
        send_operands(68, 34);                      // overflow before the last step
        send_operands(66, 33);
        send_operands(64'h1_0000_0000, 2);
        send_operands(64'h2_0000_0000, 2);
        send_operands(64'h8000_0000_0000_0000, 1);
        send_operands(100, 50);
        wait_for_results();
    endtask

    // Result side stalls long enough that the unit fills and holds off operands;
    // two items of up to ten iterations each finish well inside the stall.
    task automatic test_output_backpressure();
        int j;
        hold_request = 4000;
        for (j = 0; j < 12; j++)
            send_operands(FIELD_WIDTH'($urandom_range(0, 20)),
                          FIELD_WIDTH'($urandom_range(0, 24)));
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        int j;
        no_gaps = 1'b1;
        for (j = 0; j < 20; j++)
            send_operands(FIELD_WIDTH'($urandom_range(0, 40)),
                          FIELD_WIDTH'($urandom_range(0, 42)));
        wait_for_results();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_operands(input int count);
        int                     j;
        int                     pick;
        logic [FIELD_WIDTH-1:0] d;
        logic [FIELD_WIDTH-1:0] n;
        logic [FIELD_WIDTH-1:0] k;
        for (j = 0; j < count; j++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3:
                begin
                    n = FIELD_WIDTH'($urandom_range(0, 70));
                    k = FIELD_WIDTH'($urandom_range(0, int'(n) + 3));
                end
                4:
                begin
                    n = FIELD_WIDTH'($urandom_range(0, 70));
                    k = rand_word();
                end
                5:
                begin
                    n = rand_word();
                    k = FIELD_WIDTH'($urandom_range(0, 4));
                end
                6:
                begin
                    n = rand_word();
                    d = FIELD_WIDTH'($urandom_range(0, 4));
                    k = (n >= d) ? n - d : '0;
                end
                7:
                begin
                    n = rand_word();
                    k = rand_word();
                end
                8:
                begin
                    n = FIELD_WIDTH'($urandom_range(71, 2000));
                    k = FIELD_WIDTH'($urandom_range(0, int'(n)));
                end
                default:
                begin
                    n = rand_word() >> $urandom_range(0, 63);
                    k = rand_word() >> $urandom_range(0, 63);
                end
            endcase
            send_operands(n, k);
            // occasionally let the pipe drain so the next item meets an idle unit
            if ($urandom_range(0, 15) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        operands_ch.valid    <= 1'b0;
        operands_ch.n_total  <= '0;
        operands_ch.k_chosen <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_operands();
        test_output_backpressure();
        test_back_to_back();
        test_random_operands(195);
        wait_for_results();
        repeat (200) @(posedge clk);

        $display("Ran %0d operand pairs (edges, stalls, back-to-back, random); %0d results checked",
                 items_sent, results_taken);
        $display("  %0d saturated on overflow, %0d came out zero", overflows, zeros);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("binomial_coefficient: match");
        else
            $display("binomial_coefficient: mismatch");
        $finish;
    end

endmodule

### binomial_coefficient.f
rtl/bc_pkg.sv
rtl/bc_in_if.sv
rtl/bc_out_if.sv
rtl/bc_datapath.sv
rtl/bc_control.sv
rtl/binomial_coefficient.sv
verif/tb_binomial_coefficient.sv
